// ===== hw/rtl/vib_pkg.sv =====
// shared types, constants and the quarter-wave sine table for the vibrato block
package vib_pkg;

   // delay line, must be a power of two
   localparam int BUFFER_DEPTH = 32768;
   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int SAMPLE_W = 24;
   localparam int CSR_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int PHASE_W = 16;
   localparam int FRAC_W = 16;
   localparam int POS_W = ADDR_W + FRAC_W;
   localparam int SPAN_W = POS_W + 1;
   localparam int DLY_PROD_W = CSR_W + CSR_W + 1;
   localparam logic [DLY_PROD_W-1:0] SPAN_LIMIT = DLY_PROD_W'(1) << POS_W;

   // sine table, must be a power of two
   localparam int SINE_TABLE_SIZE = 1024;
   localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);
   localparam int SINE_SHIFT = PHASE_W - SINE_BITS;
   localparam int QUARTER = SINE_TABLE_SIZE / 4;
   localparam int QK_W = SINE_BITS - 1;
   localparam logic [31:0] SIN_A = 32'd51472;
   localparam logic [31:0] SIN_B = 32'd21024;
   localparam logic [31:0] SIN_C = 32'd2320;

   localparam logic [CSR_W-1:0] BASE_DELAY_RST = 16'd24000;
   localparam logic [CSR_W-1:0] MOD_DEPTH_RST = 16'd20972;
   localparam logic [CSR_W-1:0] PHASE_STEP_RST = 16'd2086;
   localparam logic [PHASE_W-1:0] PHASE_RST = 16'd8;

   // decoupling queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_DELAY = 2'd0,
      CSR_MOD_DEPTH  = 2'd1,
      CSR_PHASE_STEP = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CSR_W-1:0] base_delay;
      logic [CSR_W-1:0] mod_depth;
      logic [CSR_W-1:0] phase_step;
   } cfg_type;

   // one classified transaction waiting for the back end
   typedef struct packed {
      logic [ADDR_W-1:0]          ip;
      logic [FRAC_W-1:0]          frac;
      logic [ADDR_W-1:0]          wp;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       valid_a;
      logic                       valid_b;
   } entry_type;

   typedef logic [15:0] qsine_tab_type [QUARTER+1];

   function automatic logic [15:0] quarter_sine(input logic [31:0] z);
      logic [31:0] z2;
      logic [31:0] inner;
      logic [31:0] outer;
      logic [31:0] r;
      z2 = (z * z) >> 14;
      inner = SIN_B - ((z2 * SIN_C) >> 14);
      outer = SIN_A - ((z2 * inner) >> 14);
      r = (z * outer) >> 14;
      if (r > 32'd32767) begin
         r = 32'd32767;
      end
      return r[15:0];
   endfunction

   function automatic qsine_tab_type build_qsine();
      qsine_tab_type tab;
      for (int k = 0; k <= QUARTER; k++) begin
         tab[k] = quarter_sine(32'(k) << SINE_SHIFT);
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE_TAB = build_qsine();

endpackage

// ===== hw/rtl/vib_ram.sv =====
// generic single-port ram with registered read
module vib_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end else begin
         rdata <= mem[addr];
      end
   end

endmodule

// ===== hw/rtl/vib_front.sv =====
// front end: accepts samples, runs the lfo and computes the fractional read position
module vib_front import vib_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       push_valid,
   input  logic                       push_ready,
   output entry_type                  push_data
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MOD  = 4'b0010,
      F_DLY  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type            state_ff, state_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [ADDR_W-1:0]          wp_ff, wp_in;
   logic                       wrapped_ff, wrapped_in;
   logic [ADDR_W-1:0]          item_wp_ff, item_wp_in;
   logic                       item_wrapped_ff, item_wrapped_in;
   logic signed [SAMPLE_W-1:0] item_sample_ff, item_sample_in;
   logic [CSR_W-1:0]           s_ff, s_in;
   logic [CSR_W-1:0]           m_ff, m_in;
   logic [SPAN_W-1:0]          dly_ff, dly_in;

   logic [SINE_BITS-1:0]       idx;
   logic [1:0]                 quad;
   logic [SINE_BITS-3:0]       qi;
   logic [QK_W-1:0]            qk;
   logic [15:0]                sine_mag;
   logic [CSR_W-1:0]           s_lookup;
   logic [2*CSR_W-1:0]         mod_prod;
   logic [DLY_PROD_W-1:0]      dly_prod;
   logic [DLY_PROD_W-1:0]      dly_clamped;
   logic [POS_W-1:0]           rp;
   logic [ADDR_W-1:0]          ip;
   logic [ADDR_W-1:0]          ipn;

   // quarter-wave lookup of the lfo, offset to 1..65535
   assign idx = phase_ff[PHASE_W-1 -: SINE_BITS];
   assign quad = idx[SINE_BITS-1 -: 2];
   assign qi = idx[SINE_BITS-3:0];
   assign qk = quad[0] ? (QK_W'(QUARTER) - {1'b0, qi}) : {1'b0, qi};
   assign sine_mag = QSINE_TAB[qk];
   assign s_lookup = quad[1] ? (16'h8000 - sine_mag) : (16'h8000 + sine_mag);

   assign mod_prod = s_ff * cfg.mod_depth;
   assign dly_prod = DLY_PROD_W'(cfg.base_delay) * DLY_PROD_W'({1'b1, m_ff});
   assign dly_clamped = (dly_prod > SPAN_LIMIT) ? SPAN_LIMIT : dly_prod;

   // read position wraps naturally since the depth is a power of two
   assign rp = {item_wp_ff, {FRAC_W{1'b0}}} - POS_W'(dly_ff);
   assign ip = rp[POS_W-1:FRAC_W];
   assign ipn = ip + ADDR_W'(1);

   assign req_ready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);

   always_comb begin
      push_data.ip = ip;
      push_data.frac = rp[FRAC_W-1:0];
      push_data.wp = item_wp_ff;
      push_data.sample = item_sample_ff;
      // entries not yet written since reset read as zero
      push_data.valid_a = item_wrapped_ff || (ip < item_wp_ff);
      push_data.valid_b = item_wrapped_ff || (ipn < item_wp_ff);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      wp_in = wp_ff;
      wrapped_in = wrapped_ff;
      item_wp_in = item_wp_ff;
      item_wrapped_in = item_wrapped_ff;
      item_sample_in = item_sample_ff;
      s_in = s_ff;
      m_in = m_ff;
      dly_in = dly_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = F_MOD;
               item_sample_in = req_sample_in;
               item_wp_in = wp_ff;
               item_wrapped_in = wrapped_ff;
               s_in = s_lookup;
               wp_in = wp_ff + ADDR_W'(1);
               if (&wp_ff) begin
                  wrapped_in = 1'b1;
               end
               phase_in = phase_ff + cfg.phase_step;
            end
         end
         F_MOD: begin
            m_in = mod_prod[2*CSR_W-1:CSR_W];
            state_in = F_DLY;
         end
         F_DLY: begin
            dly_in = SPAN_W'(dly_clamped);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= PHASE_RST;
         wp_ff <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wp_ff <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   always_ff @(posedge clock) begin
      item_wp_ff <= item_wp_in;
      item_wrapped_ff <= item_wrapped_in;
      item_sample_ff <= item_sample_in;
      s_ff <= s_in;
      m_ff <= m_in;
      dly_ff <= dly_in;
   end

endmodule

// ===== hw/rtl/vib_queue.sv =====
// short fifo of classified transactions between front and back
module vib_queue import vib_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_taken,
   output entry_type pop_data
);

   entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_taken && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue holds more than its depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_taken |-> count_ff != '0)
      else $error("back end popped an empty queue");
`endif

endmodule

// ===== hw/rtl/vib_back.sv =====
// back end: reads the two neighbors, writes the new sample, interpolates
module vib_back import vib_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_taken,
   input  entry_type                  pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   localparam int PROD_W = SAMPLE_W + 1 + FRAC_W + 1;
   localparam int ACC_W = PROD_W + 1;
   localparam int RES_W = ACC_W - FRAC_W;
   localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_W - 1));

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_RDB  = 5'b00010,
      B_WR   = 5'b00100,
      B_MUL  = 5'b01000,
      B_OUT  = 5'b10000
   } back_state_type;

   back_state_type             state_ff, state_in;
   entry_type                  work_ff, work_in;
   logic signed [SAMPLE_W-1:0] a_ff, a_in;
   logic signed [SAMPLE_W-1:0] b_ff, b_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_addr;
   logic [SAMPLE_W-1:0]        ram_wdata;
   logic [SAMPLE_W-1:0]        ram_rdata;

   logic signed [SAMPLE_W:0]   diff;
   logic signed [PROD_W-1:0]   prod_calc;
   logic signed [ACC_W-1:0]    acc;
   logic signed [RES_W-1:0]    res;
   logic signed [RES_W-1:0]    res_sat;
   logic                       rsp_free;

   vib_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_line (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // a*(1-f) + b*f written as a + (b-a)*f
   assign diff = (SAMPLE_W + 1)'(b_ff) - (SAMPLE_W + 1)'(a_ff);
   assign prod_calc = diff * $signed({1'b0, work_ff.frac});
   assign acc = (ACC_W'(a_ff) <<< FRAC_W) + ACC_W'(prod_ff) + ROUND_HALF;
   assign res = acc[ACC_W-1:FRAC_W];
   assign res_sat = (res > RES_MAX) ? RES_MAX : ((res < RES_MIN) ? RES_MIN : res);

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      work_in = work_ff;
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop_taken = 1'b0;
      ram_we = 1'b0;
      ram_addr = work_ff.ip;
      ram_wdata = work_ff.sample;
      case (state_ff)
         B_IDLE: begin
            ram_addr = pop_data.ip;
            if (pop_valid) begin
               pop_taken = 1'b1;
               work_in = pop_data;
               state_in = B_RDB;
            end
         end
         B_RDB: begin
            ram_addr = work_ff.ip + ADDR_W'(1);
            a_in = work_ff.valid_a ? $signed(ram_rdata) : '0;
            state_in = B_WR;
         end
         B_WR: begin
            // read of both neighbors is done, the oldest slot can be overwritten
            ram_we = 1'b1;
            ram_addr = work_ff.wp;
            b_in = work_ff.valid_b ? $signed(ram_rdata) : '0;
            state_in = B_MUL;
         end
         B_MUL: begin
            prod_in = prod_calc;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = SAMPLE_W'(res_sat);
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && rsp_free) |=> (rsp_valid_ff && state_ff == B_IDLE))
      else $error("finished transaction not moved to the output register");
   a_write_after_reads: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> $past(state_ff == B_RDB))
      else $error("delay line written before both neighbors were read");
`endif

endmodule

// ===== hw/rtl/modulated_delay_vibrato.sv =====
// top level of the vibrato block: register file, front end, queue and back end
//
//   channel  dir  handshake                 payload
//   req      in   req_valid / req_ready     req_sample_in  (signed 24)
//   rsp      out  rsp_valid / rsp_ready     rsp_sample_out (signed 24)
//   csr      in   csr_valid / csr_ready     csr_index (2), csr_wdata (16)
//
// the front end steps through sine lookup, depth multiply, delay multiply and read position
// subtract for each sample. the back end does two reads and one write on the single-port
// delay line ram, then the interpolation multiply and rounding. sustained rate is set by
// the back end and its delay line ram port; the queue lets the front end take new samples.
// reset restores registers, write pointer and lfo phase; no clearing pass, unwritten
// delay line slots are masked by a wrap flag and read as zero.
// a stalled rsp side fills the output register, the back end and the queue, then holds req_ready low.
module modulated_delay_vibrato import vib_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_taken;
   entry_type pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_DELAY: cfg_in.base_delay = csr_wdata;
            CSR_MOD_DEPTH:  cfg_in.mod_depth = csr_wdata;
            CSR_PHASE_STEP: cfg_in.phase_step = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_delay <= BASE_DELAY_RST;
         cfg_ff.mod_depth <= MOD_DEPTH_RST;
         cfg_ff.phase_step <= PHASE_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vib_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   vib_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_taken  (pop_taken),
      .pop_data   (pop_data)
   );

   vib_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_taken      (pop_taken),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ===== tb/modulated_delay_vibrato_test.sv =====
// self-checking testbench for the vibrato block: directed script, then random audio and settings
`timescale 1ns / 1ps

module modulated_delay_vibrato_test;
   import vib_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
   localparam longint LINE_SPAN = longint'(BUFFER_DEPTH) << FRAC_W;
   localparam int unsigned POLY_A = 51472;
   localparam int unsigned POLY_B = 21024;
   localparam int unsigned POLY_C = 2320;
   localparam int SEGMENTS = 4;
   localparam int SEGMENT_ITEMS = 140;
   localparam int DRAIN_CYCLES = 40;

   // idle percentages per phase: sender, then receiver
   localparam int SEND_IDLE_PCT [3] = '{18, 67, 0};
   localparam int RECV_IDLE_PCT [3] = '{67, 18, 0};
   // first setting of each phase is an extreme one
   localparam logic [CSR_W-1:0] EXTREME_BASE [3] = '{16'd0, 16'd65535, 16'd32768};
   localparam logic [CSR_W-1:0] EXTREME_DEPTH [3] = '{16'd0, 16'd65535, 16'd65535};
   localparam logic [CSR_W-1:0] EXTREME_RATE [3] = '{16'd0, 16'd65535, 16'd1};

   typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_W-1:0]      wdata;
      logic [SAMPLE_W-1:0]   audio;
      logic                  typed_in;
      logic [SAMPLE_W-1:0]   expected;
   } script_row_type;

   localparam int SCRIPT_LEN = 31;
   localparam script_row_type DIRECTED_SCRIPT [SCRIPT_LEN] = '{
      // deep modulation on a one-sample delay: first read lands in the zeroed tail
      '{ROW_WRITE,  CSR_BASE_DELAY, 16'd1,     24'h0,      1'b0, 24'h0},
      '{ROW_WRITE,  CSR_MOD_DEPTH,  16'd65535, 24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MAX, 1'b1, 24'h0},
      // read wraps to the last entry, interpolating toward entry 0
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h000001, 1'b0, 24'h0},
      // exact one-sample delay echoes the previous transaction
      '{ROW_WRITE,  CSR_MOD_DEPTH,  16'd0,     24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MIN, 1'b1, 24'h000001},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h123456, 1'b1, SAMPLE_MIN},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h000000, 1'b1, 24'h123456},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'hFFFFFF, 1'b1, 24'h000000},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h555555, 1'b1, 24'hFFFFFF},
      // zero delay reads the slot about to be written, still empty
      '{ROW_WRITE,  CSR_BASE_DELAY, 16'd0,     24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h2AAAAA, 1'b1, 24'h0},
      // delay of exactly the whole line
      '{ROW_WRITE,  CSR_BASE_DELAY, 16'd32768, 24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MAX, 1'b1, 24'h0},
      // delay beyond the line is clamped
      '{ROW_WRITE,  CSR_BASE_DELAY, 16'd65535, 24'h0,      1'b0, 24'h0},
      '{ROW_WRITE,  CSR_MOD_DEPTH,  16'd65535, 24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MIN, 1'b1, 24'h0},
      '{ROW_WRITE,  CSR_BASE_DELAY, 16'd2,     24'h0,      1'b0, 24'h0},
      '{ROW_WRITE,  CSR_MOD_DEPTH,  16'd0,     24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h3C3C3C, 1'b1, SAMPLE_MAX},
      // fractional reads between full-scale neighbors
      '{ROW_WRITE,  CSR_BASE_DELAY, 16'd3,     24'h0,      1'b0, 24'h0},
      '{ROW_WRITE,  CSR_MOD_DEPTH,  16'd32768, 24'h0,      1'b0, 24'h0},
      '{ROW_WRITE,  CSR_PHASE_STEP, 16'd65535, 24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MAX, 1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MIN, 1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     SAMPLE_MAX, 1'b0, 24'h0},
      // write to an index past the register list must change nothing
      '{ROW_WRITE,  CSR_UNUSED,     16'hFFFF,  24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'hC3C3C3, 1'b0, 24'h0},
      '{ROW_WRITE,  CSR_PHASE_STEP, 16'd0,     24'h0,      1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'h0F0F0F, 1'b0, 24'h0},
      '{ROW_SAMPLE, CSR_BASE_DELAY, 16'd0,     24'hF0F0F0, 1'b0, 24'h0}
   };

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_W-1:0]           csr_wdata;

   // predictor state
   int                         lfo_table [SINE_TABLE_SIZE];
   logic signed [SAMPLE_W-1:0] delay_store [BUFFER_DEPTH];
   logic [ADDR_W-1:0]          pred_wp;
   logic [PHASE_W-1:0]         pred_phase;
   logic [CSR_W-1:0]           cfg_base_delay;
   logic [CSR_W-1:0]           cfg_mod_depth;
   logic [CSR_W-1:0]           cfg_phase_step;

   logic signed [SAMPLE_W-1:0] expected_samples [$];
   int                         failures = 0;
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;

   modulated_delay_vibrato DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // interpolated tap of the line for the current lfo phase, then store the new sample
   function automatic logic signed [SAMPLE_W-1:0] predict_delayed_sample(
         input logic signed [SAMPLE_W-1:0] audio);
      longint depth;
      longint base;
      longint lifted;
      longint swing;
      longint span_dly;
      longint wq;
      longint rp;
      longint ip;
      longint ipn;
      longint f;
      longint a;
      longint b;
      longint v;
      longint res;
      depth = cfg_mod_depth;
      base = cfg_base_delay;
      lifted = lfo_table[(int'(pred_phase) * SINE_TABLE_SIZE) >> PHASE_W] + 32768;
      swing = (lifted * depth) >> 16;
      span_dly = base * (65536 + swing);
      if (span_dly > LINE_SPAN) begin
         span_dly = LINE_SPAN;
      end
      wq = longint'(pred_wp) << FRAC_W;
      rp = (wq >= span_dly) ? wq - span_dly : wq + LINE_SPAN - span_dly;
      if (rp >= LINE_SPAN) begin
         rp = rp - LINE_SPAN;
      end
      ip = rp >> FRAC_W;
      f = rp & 64'hFFFF;
      ipn = (ip + 1) % BUFFER_DEPTH;
      a = delay_store[ip];
      b = delay_store[ipn];
      v = a * (65536 - f) + b * f;
      res = (v + 32768) >>> 16;
      if (res > 8388607) begin
         res = 8388607;
      end
      if (res < -8388608) begin
         res = -8388608;
      end
      delay_store[pred_wp] = audio;
      pred_wp = pred_wp + 1'b1;  // wraps at the end of the line
      pred_phase = pred_phase + cfg_phase_step;
      return res[SAMPLE_W-1:0];
   endfunction

   // enters and leaves at a falling edge with req_valid still high
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] audio,
                              input logic typed_in,
                              input logic signed [SAMPLE_W-1:0] typed_value);
      logic signed [SAMPLE_W-1:0] predicted;
      csr_valid <= 1'b0;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= audio;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      predicted = predict_delayed_sample(audio);
      expected_samples.push_back(typed_in ? typed_value : predicted);
      @(negedge clock);
   endtask

   // settings change only once every result is back
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_W-1:0] wdata);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (index)
         CSR_BASE_DELAY: cfg_base_delay = wdata;
         CSR_MOD_DEPTH:  cfg_mod_depth = wdata;
         CSR_PHASE_STEP: cfg_phase_step = wdata;
         default: ;
      endcase
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: expected none, actual %0d", rsp_sample_out);
            failures++;
         end else begin
            if (rsp_sample_out !== expected_samples[0]) begin
               $error("sample_out: expected %0d, actual %0d",
                      expected_samples[0], rsp_sample_out);
               failures++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   initial begin
      int unsigned t;
      int unsigned x;
      int unsigned z;
      int unsigned z2;
      int unsigned inner;
      int unsigned outer;
      int unsigned r;
      logic [CSR_W-1:0] base;
      logic [CSR_W-1:0] depth;
      logic [CSR_W-1:0] rate;
      logic signed [SAMPLE_W-1:0] audio;

      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      // lfo table: quarter-wave polynomial, mirrored and negated per quadrant
      for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
         t = (k * 65536) / SINE_TABLE_SIZE;
         x = t & 16383;
         z = t[14] ? 16384 - x : x;
         z2 = (z * z) >> 14;
         inner = POLY_B - ((z2 * POLY_C) >> 14);
         outer = POLY_A - ((z2 * inner) >> 14);
         r = (z * outer) >> 14;
         if (r > 32767) begin
            r = 32767;
         end
         lfo_table[k] = t[15] ? -int'(r) : int'(r);
      end
      foreach (delay_store[k]) begin
         delay_store[k] = '0;
      end
      pred_wp = '0;
      pred_phase = PHASE_RST;
      cfg_base_delay = BASE_DELAY_RST;
      cfg_mod_depth = MOD_DEPTH_RST;
      cfg_phase_step = PHASE_STEP_RST;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = SEND_IDLE_PCT[0];
      recv_idle_pct = RECV_IDLE_PCT[0];
      foreach (DIRECTED_SCRIPT[n]) begin
         if (DIRECTED_SCRIPT[n].kind == ROW_WRITE) begin
            write_register(DIRECTED_SCRIPT[n].index, DIRECTED_SCRIPT[n].wdata);
         end else begin
            send_sample(DIRECTED_SCRIPT[n].audio, DIRECTED_SCRIPT[n].typed_in,
                        DIRECTED_SCRIPT[n].expected);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SEND_IDLE_PCT[phase];
         recv_idle_pct = RECV_IDLE_PCT[phase];
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
               base = EXTREME_BASE[phase];
               depth = EXTREME_DEPTH[phase];
               rate = EXTREME_RATE[phase];
            end else begin
               // short delays mostly, so the taps land on written samples
               base = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(700, 0);
               depth = $urandom;
               rate = $urandom;
            end
            write_register(CSR_BASE_DELAY, base);
            write_register(CSR_MOD_DEPTH, depth);
            write_register(CSR_PHASE_STEP, rate);
            if ($urandom_range(2, 0) == 0) begin
               write_register(CSR_UNUSED, $urandom);
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
               if ($urandom_range(7, 0) == 0) begin
                  audio = $urandom_range(1, 0) ? SAMPLE_MAX : SAMPLE_MIN;
               end else begin
                  audio = $urandom;
               end
               send_sample(audio, 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule
